// ----- sv/sbo_pkg.sv -----
// Shared constants, types and helpers for the sphere/box overlap test.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sbo_pkg;

   localparam int FIELD_BITS = 64;
   localparam int COORD_BITS = 64;
   localparam int LO_BITS    = (COORD_BITS + 1) / 2;
   localparam int HI_BITS    = COORD_BITS - LO_BITS;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int SUM_BITS   = 2 * COORD_BITS + 2;
   localparam int NUM_STAGES = 7;

   localparam logic OP_SPHERE = 1'b0;
   localparam logic OP_BOX    = 1'b1;

   typedef logic signed [FIELD_BITS-1:0] field_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [COORD_BITS-1:0] mag_type;
   typedef logic        [SQ_BITS-1:0]    sq_type;
   typedef logic        [SQ_BITS:0]      reach2_type;
   typedef logic        [SUM_BITS-1:0]   sum_type;
   typedef logic        [NUM_STAGES-1:0] stage_en_type;

   function automatic coord_type to_coord(input field_type f);
      return coord_type'(f[COORD_BITS-1:0]);
   endfunction

   function automatic mag_type magnitude(input coord_type v);
      return v[COORD_BITS-1] ? mag_type'(0) - mag_type'(v) : mag_type'(v);
   endfunction

endpackage

`default_nettype wire

// ----- sv/sbo_if.sv -----
// Valid/ready channel interfaces for query transfers and hit results.
// Depends on sbo_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sbo_req_if;
   logic                valid;
   logic                ready;
   logic                op;
   sbo_pkg::field_type  obj_x;
   sbo_pkg::field_type  obj_y;
   sbo_pkg::field_type  obj_z;
   sbo_pkg::field_type  obj_radius;
   sbo_pkg::field_type  q_a_x;
   sbo_pkg::field_type  q_a_y;
   sbo_pkg::field_type  q_a_z;
   sbo_pkg::field_type  q_b_x;
   sbo_pkg::field_type  q_b_y;
   sbo_pkg::field_type  q_b_z;
   sbo_pkg::field_type  q_radius;

   modport source (output valid, op, obj_x, obj_y, obj_z, obj_radius,
                   q_a_x, q_a_y, q_a_z, q_b_x, q_b_y, q_b_z, q_radius,
                   input ready);
   modport sink (input valid, op, obj_x, obj_y, obj_z, obj_radius,
                 q_a_x, q_a_y, q_a_z, q_b_x, q_b_y, q_b_z, q_radius,
                 output ready);
endinterface

interface sbo_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

// ----- sv/sbo_axis.sv -----
// One axis of the offset path: clamp point select, then absolute offset.
// Depends on sbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbo_axis (
   input  wire logic               clock,
   input  wire logic               adv_clamp,
   input  wire logic               adv_diff,
   input  wire logic               box,
   input  wire sbo_pkg::coord_type center,
   input  wire sbo_pkg::coord_type lo,
   input  wire sbo_pkg::coord_type hi,
   output sbo_pkg::mag_type        offset
);

   sbo_pkg::coord_type clamp;
   sbo_pkg::coord_type point_in, point_ff;
   sbo_pkg::coord_type center_in, center_ff;
   sbo_pkg::mag_type   offset_in, offset_ff;

   always_comb begin
      if (center < lo) begin
         clamp = lo;
      end else if (hi < center) begin
         clamp = hi;
      end else begin
         clamp = center;
      end
      point_in  = box ? clamp : lo;
      center_in = center;
      offset_in = (center_ff < point_ff)
                ? sbo_pkg::mag_type'(point_ff) - sbo_pkg::mag_type'(center_ff)
                : sbo_pkg::mag_type'(center_ff) - sbo_pkg::mag_type'(point_ff);
   end

   always_ff @(posedge clock) begin
      if (adv_clamp) begin
         point_ff  <= point_in;
         center_ff <= center_in;
      end
      if (adv_diff) begin
         offset_ff <= offset_in;
      end
   end

   assign offset = offset_ff;

endmodule

`default_nettype wire

// ----- sv/sbo_reach.sv -----
// Reach magnitude: |obj_radius| for a box, |obj_radius + q_radius| for a sphere.
// Depends on sbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbo_reach (
   input  wire logic               clock,
   input  wire logic               adv_mag,
   input  wire logic               adv_sum,
   input  wire logic               box,
   input  wire sbo_pkg::coord_type obj_radius,
   input  wire sbo_pkg::coord_type q_radius,
   output sbo_pkg::mag_type        reach,
   output logic                    reach_top
);

   sbo_pkg::mag_type              m1_in, m1_ff;
   sbo_pkg::mag_type              m2_in, m2_ff;
   logic                          same_in, same_ff;
   logic                          box_in, box_ff;
   logic [sbo_pkg::COORD_BITS:0]  total;
   sbo_pkg::mag_type              diff;
   sbo_pkg::mag_type              reach_in, reach_ff;
   logic                          top_in, top_ff;

   always_comb begin
      m1_in   = sbo_pkg::magnitude(obj_radius);
      m2_in   = sbo_pkg::magnitude(q_radius);
      same_in = obj_radius[sbo_pkg::COORD_BITS-1] == q_radius[sbo_pkg::COORD_BITS-1];
      box_in  = box;

      total = {1'b0, m1_ff} + {1'b0, m2_ff};
      diff  = (m1_ff > m2_ff) ? m1_ff - m2_ff : m2_ff - m1_ff;
      if (box_ff) begin
         reach_in = m1_ff;
         top_in   = 1'b0;
      end else if (same_ff) begin
         reach_in = total[sbo_pkg::COORD_BITS-1:0];
         top_in   = total[sbo_pkg::COORD_BITS];
      end else begin
         reach_in = diff;
         top_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_mag) begin
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         same_ff <= same_in;
         box_ff  <= box_in;
      end
      if (adv_sum) begin
         reach_ff <= reach_in;
         top_ff   <= top_in;
      end
   end

   assign reach     = reach_ff;
   assign reach_top = top_ff;

endmodule

`default_nettype wire

// ----- sv/sbo_square.sv -----
// Two-stage squarer: half-width partial products, then recombination.
// Depends on sbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbo_square (
   input  wire logic             clock,
   input  wire logic             adv_mul,
   input  wire logic             adv_sum,
   input  wire sbo_pkg::mag_type value,
   output sbo_pkg::sq_type       square
);

   localparam int LO = sbo_pkg::LO_BITS;
   localparam int HI = sbo_pkg::HI_BITS;

   logic [LO-1:0]      lo;
   logic [HI-1:0]      hi;
   logic [2*LO-1:0]    ll_in, ll_ff;
   logic [LO+HI-1:0]   lh_in, lh_ff;
   logic [2*HI-1:0]    hh_in, hh_ff;
   sbo_pkg::sq_type    sq_in, sq_ff;

   always_comb begin
      lo    = value[LO-1:0];
      hi    = value[sbo_pkg::COORD_BITS-1:LO];
      ll_in = {{LO{1'b0}}, lo} * {{LO{1'b0}}, lo};
      lh_in = {{HI{1'b0}}, lo} * {{LO{1'b0}}, hi};
      hh_in = {{HI{1'b0}}, hi} * {{HI{1'b0}}, hi};
      sq_in = (sbo_pkg::sq_type'(hh_ff) << (2 * LO))
            + (sbo_pkg::sq_type'(lh_ff) << (LO + 1))
            + sbo_pkg::sq_type'(ll_ff);
   end

   always_ff @(posedge clock) begin
      if (adv_mul) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hh_ff <= hh_in;
      end
      if (adv_sum) begin
         sq_ff <= sq_in;
      end
   end

   assign square = sq_ff;

endmodule

`default_nettype wire

// ----- sv/sphere_box_overlap_test.sv -----
// Top level of the sphere/box overlap test: stage control, sum and compare.
// Depends on sbo_pkg, sbo_if, sbo_axis, sbo_reach and sbo_square.
//
// Usage:
//   req_chan carries one object (center, radius) and one query per transfer.
//   op selects a sphere query (q_a center, q_radius) or an axis-aligned box
//   query (q_a minimum corner, q_b maximum corner). rsp_chan returns one hit
//   bit per query, in order: 1 when the squared distance from the object
//   center to the query is at most the squared reach, computed exactly.
//   Pipeline: a request reaches response valid through seven registers
//   (input, clamp, offset, partial products, squares, sum, compare).
//   Throughput: one query per cycle while rsp_chan accepts results; every stage holds one item.
//   Stall: with rsp_chan.ready low, the output register holds its result and
//   stages behind it keep filling empty slots; req_chan.ready drops only once
//   every stage holds an item.
//   Reset: synchronous, active high; empties every stage, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module sphere_box_overlap_test (
   input wire logic  clock,
   input wire logic  reset,
   sbo_req_if.sink   req_chan,
   sbo_rsp_if.source rsp_chan
);

   localparam int N = sbo_pkg::NUM_STAGES;

   sbo_pkg::stage_en_type adv;
   logic [N-1:0]          valid_in, valid_ff;

   logic                  box_in, box_ff;
   sbo_pkg::coord_type    obj_x_in, obj_x_ff, obj_y_in, obj_y_ff, obj_z_in, obj_z_ff;
   sbo_pkg::coord_type    obj_r_in, obj_r_ff, q_r_in, q_r_ff;
   sbo_pkg::coord_type    a_x_in, a_x_ff, a_y_in, a_y_ff, a_z_in, a_z_ff;
   sbo_pkg::coord_type    b_x_in, b_x_ff, b_y_in, b_y_ff, b_z_in, b_z_ff;

   sbo_pkg::mag_type      dx, dy, dz, reach;
   logic                  reach_top;
   logic                  top4_in, top4_ff, top5_in, top5_ff;
   sbo_pkg::sq_type       sq_x, sq_y, sq_z, sq_r;
   sbo_pkg::sum_type      sum_in, sum_ff;
   sbo_pkg::reach2_type   r2_in, r2_ff;
   logic                  hit_in, hit_ff;

   // advance a stage when it is empty or the stage after it advances
   always_comb begin
      adv[N-1] = !valid_ff[N-1] || rsp_chan.ready;
      for (int k = N - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = req_chan.valid;
      for (int k = 1; k < N; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_comb begin
      box_in   = req_chan.op == sbo_pkg::OP_BOX;
      obj_x_in = sbo_pkg::to_coord(req_chan.obj_x);
      obj_y_in = sbo_pkg::to_coord(req_chan.obj_y);
      obj_z_in = sbo_pkg::to_coord(req_chan.obj_z);
      obj_r_in = sbo_pkg::to_coord(req_chan.obj_radius);
      a_x_in   = sbo_pkg::to_coord(req_chan.q_a_x);
      a_y_in   = sbo_pkg::to_coord(req_chan.q_a_y);
      a_z_in   = sbo_pkg::to_coord(req_chan.q_a_z);
      b_x_in   = sbo_pkg::to_coord(req_chan.q_b_x);
      b_y_in   = sbo_pkg::to_coord(req_chan.q_b_y);
      b_z_in   = sbo_pkg::to_coord(req_chan.q_b_z);
      q_r_in   = sbo_pkg::to_coord(req_chan.q_radius);

      top4_in = reach_top;
      top5_in = top4_ff;
      sum_in  = sbo_pkg::sum_type'(sq_x) + sbo_pkg::sum_type'(sq_y)
              + sbo_pkg::sum_type'(sq_z);
      r2_in   = top5_ff ? {1'b1, {sbo_pkg::SQ_BITS{1'b0}}} : {1'b0, sq_r};
      hit_in  = sum_ff <= sbo_pkg::sum_type'(r2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
      if (adv[0]) begin
         box_ff   <= box_in;
         obj_x_ff <= obj_x_in;
         obj_y_ff <= obj_y_in;
         obj_z_ff <= obj_z_in;
         obj_r_ff <= obj_r_in;
         a_x_ff   <= a_x_in;
         a_y_ff   <= a_y_in;
         a_z_ff   <= a_z_in;
         b_x_ff   <= b_x_in;
         b_y_ff   <= b_y_in;
         b_z_ff   <= b_z_in;
         q_r_ff   <= q_r_in;
      end
      if (adv[3]) begin
         top4_ff <= top4_in;
      end
      if (adv[4]) begin
         top5_ff <= top5_in;
      end
      if (adv[5]) begin
         sum_ff <= sum_in;
         r2_ff  <= r2_in;
      end
      if (adv[6]) begin
         hit_ff <= hit_in;
      end
   end

   sbo_axis u_axis_x (
      .clock     (clock),
      .adv_clamp (adv[1]),
      .adv_diff  (adv[2]),
      .box       (box_ff),
      .center    (obj_x_ff),
      .lo        (a_x_ff),
      .hi        (b_x_ff),
      .offset    (dx)
   );

   sbo_axis u_axis_y (
      .clock     (clock),
      .adv_clamp (adv[1]),
      .adv_diff  (adv[2]),
      .box       (box_ff),
      .center    (obj_y_ff),
      .lo        (a_y_ff),
      .hi        (b_y_ff),
      .offset    (dy)
   );

   sbo_axis u_axis_z (
      .clock     (clock),
      .adv_clamp (adv[1]),
      .adv_diff  (adv[2]),
      .box       (box_ff),
      .center    (obj_z_ff),
      .lo        (a_z_ff),
      .hi        (b_z_ff),
      .offset    (dz)
   );

   sbo_reach u_reach (
      .clock      (clock),
      .adv_mag    (adv[1]),
      .adv_sum    (adv[2]),
      .box        (box_ff),
      .obj_radius (obj_r_ff),
      .q_radius   (q_r_ff),
      .reach      (reach),
      .reach_top  (reach_top)
   );

   sbo_square u_sq_x (
      .clock   (clock),
      .adv_mul (adv[3]),
      .adv_sum (adv[4]),
      .value   (dx),
      .square  (sq_x)
   );

   sbo_square u_sq_y (
      .clock   (clock),
      .adv_mul (adv[3]),
      .adv_sum (adv[4]),
      .value   (dy),
      .square  (sq_y)
   );

   sbo_square u_sq_z (
      .clock   (clock),
      .adv_mul (adv[3]),
      .adv_sum (adv[4]),
      .value   (dz),
      .square  (sq_z)
   );

   sbo_square u_sq_r (
      .clock   (clock),
      .adv_mul (adv[3]),
      .adv_sum (adv[4]),
      .value   (reach),
      .square  (sq_r)
   );

   assign req_chan.ready = adv[0];
   assign rsp_chan.valid = valid_ff[N-1];
   assign rsp_chan.hit   = hit_ff;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for sphere_box_overlap_test: random and directed queries.
// Predicts each hit bit exactly and checks the responses in order.
// Depends on sbo_pkg, sbo_if and the sphere_box_overlap_test RTL.
`timescale 1ns / 1ps

module tb;

   localparam int                 NUM_ITEMS      = 850;
   localparam int                 WATCHDOG_LIMIT = 5000;
   localparam int                 IDLE_PCT       = 18;
   localparam int                 MAX_REPORTS    = 10;
   localparam sbo_pkg::field_type F_MIN          = 64'sh8000_0000_0000_0000;
   localparam sbo_pkg::field_type F_MAX          = 64'sh7fff_ffff_ffff_ffff;

   typedef logic signed [67:0] wide_type;
   typedef logic [135:0]       square_type;

   typedef struct packed {
      logic               op;
      sbo_pkg::field_type obj_x;
      sbo_pkg::field_type obj_y;
      sbo_pkg::field_type obj_z;
      sbo_pkg::field_type obj_radius;
      sbo_pkg::field_type q_a_x;
      sbo_pkg::field_type q_a_y;
      sbo_pkg::field_type q_a_z;
      sbo_pkg::field_type q_b_x;
      sbo_pkg::field_type q_b_y;
      sbo_pkg::field_type q_b_z;
      sbo_pkg::field_type q_radius;
   } query_type;

   class hit_checker;
      bit pending_hits[$];
      int failures;
      int result_count;

      function wide_type coord(sbo_pkg::field_type f);
         logic signed [sbo_pkg::COORD_BITS-1:0] c;
         c = f[sbo_pkg::COORD_BITS-1:0];
         return c;
      endfunction

      function wide_type clamp(wide_type v, wide_type lo, wide_type hi);
         if (v < lo) return lo;
         if (hi < v) return hi;
         return v;
      endfunction

      function square_type square(wide_type d);
         square_type m;
         m = (d < 0) ? -d : d;
         return m * m;
      endfunction

      function bit overlap_hit(query_type q);
         wide_type ox, oy, oz, ax, ay, az, dx, dy, dz, reach;
         ox = coord(q.obj_x);
         oy = coord(q.obj_y);
         oz = coord(q.obj_z);
         ax = coord(q.q_a_x);
         ay = coord(q.q_a_y);
         az = coord(q.q_a_z);
         if (q.op == sbo_pkg::OP_BOX) begin
            dx = ox - clamp(ox, ax, coord(q.q_b_x));
            dy = oy - clamp(oy, ay, coord(q.q_b_y));
            dz = oz - clamp(oz, az, coord(q.q_b_z));
            reach = coord(q.obj_radius);
         end else begin
            dx = ox - ax;
            dy = oy - ay;
            dz = oz - az;
            reach = coord(q.obj_radius) + coord(q.q_radius);
         end
         return square(dx) + square(dy) + square(dz) <= square(reach);
      endfunction

      function void note_query(query_type q);
         pending_hits.push_back(overlap_hit(q));
      endfunction

      function void check_hit(logic hit);
         bit want;
         if (pending_hits.size() == 0) begin
            if (failures < MAX_REPORTS)
               $display("result %0d: hit %b with no query outstanding", result_count, hit);
            failures++;
         end else begin
            want = pending_hits.pop_front();
            if (hit !== want) begin
               if (failures < MAX_REPORTS)
                  $display("result %0d: hit expected %b, got %b", result_count, want, hit);
               failures++;
            end
         end
         result_count++;
      endfunction
   endclass

   logic      clock;
   logic      reset;
   bit        calm;
   int        idle_cycles;
   query_type driven_query;
   hit_checker sb = new;

   sbo_req_if req_chan ();
   sbo_rsp_if rsp_chan ();

   sphere_box_overlap_test dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #6 clock = ~clock;

   function automatic query_type mk(logic op, sbo_pkg::field_type ox,
                                    sbo_pkg::field_type oy, sbo_pkg::field_type oz,
                                    sbo_pkg::field_type orad, sbo_pkg::field_type ax,
                                    sbo_pkg::field_type ay, sbo_pkg::field_type az,
                                    sbo_pkg::field_type bx, sbo_pkg::field_type by,
                                    sbo_pkg::field_type bz, sbo_pkg::field_type qrad);
      query_type q;
      q = '{op, ox, oy, oz, orad, ax, ay, az, bx, by, bz, qrad};
      return q;
   endfunction

   function automatic sbo_pkg::field_type rand_field();
      return {$urandom, $urandom};
   endfunction

   function automatic sbo_pkg::field_type edge_field();
      case ($urandom_range(0, 5))
         0: return F_MIN;
         1: return F_MAX;
         2: return '0;
         3: return -1;
         4: return 1;
         default: return rand_field();
      endcase
   endfunction

   // offset base by a signed amount below 2^(scale+1); wraps at the extremes
   function automatic sbo_pkg::field_type near(sbo_pkg::field_type base, int scale);
      sbo_pkg::field_type off;
      off = sbo_pkg::field_type'(rand_field() >> (63 - scale));
      if ($urandom_range(0, 1)) off = -off;
      return base + off;
   endfunction

   function automatic query_type random_query();
      query_type q;
      sbo_pkg::field_type base, lo, hi, t;
      int scale;
      q = '{1'($urandom_range(0, 1)), rand_field(), rand_field(), rand_field(),
            rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
            rand_field(), rand_field(), rand_field()};
      base  = ($urandom_range(0, 3) == 0) ? edge_field() : rand_field();
      scale = $urandom_range(0, 62);
      case ($urandom_range(0, 9))
         0, 1: ;
         2: begin
            q.obj_x = edge_field(); q.obj_y = edge_field(); q.obj_z = edge_field();
            q.obj_radius = edge_field(); q.q_a_x = edge_field(); q.q_a_y = edge_field();
            q.q_a_z = edge_field(); q.q_b_x = edge_field(); q.q_b_y = edge_field();
            q.q_b_z = edge_field(); q.q_radius = edge_field();
         end
         3, 4, 5: begin
            q.op = sbo_pkg::OP_SPHERE;
            q.obj_x = near(base, scale); q.obj_y = near(base, scale);
            q.obj_z = near(base, scale);
            q.q_a_x = near(base, scale); q.q_a_y = near(base, scale);
            q.q_a_z = near(base, scale);
            q.obj_radius = near(0, scale); q.q_radius = near(0, scale);
         end
         default: begin
            q.op = sbo_pkg::OP_BOX;
            q.obj_x = near(base, scale); q.obj_y = near(base, scale);
            q.obj_z = near(base, scale);
            q.obj_radius = near(0, scale);
            for (int axis = 0; axis < 3; axis++) begin
               lo = near(base, scale);
               hi = near(base, scale);
               if (lo > hi && $urandom_range(0, 99) < 85) begin
                  t = lo; lo = hi; hi = t;
               end
               case (axis)
                  0: begin q.q_a_x = lo; q.q_b_x = hi; end
                  1: begin q.q_a_y = lo; q.q_b_y = hi; end
                  default: begin q.q_a_z = lo; q.q_b_z = hi; end
               endcase
            end
         end
      endcase
      return q;
   endfunction

   task automatic send_query(query_type q);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
      end
      @(negedge clock);
      driven_query        = q;
      req_chan.op         = q.op;
      req_chan.obj_x      = q.obj_x;
      req_chan.obj_y      = q.obj_y;
      req_chan.obj_z      = q.obj_z;
      req_chan.obj_radius = q.obj_radius;
      req_chan.q_a_x      = q.q_a_x;
      req_chan.q_a_y      = q.q_a_y;
      req_chan.q_a_z      = q.q_a_z;
      req_chan.q_b_x      = q.q_b_x;
      req_chan.q_b_y      = q.q_b_y;
      req_chan.q_b_z      = q.q_b_z;
      req_chan.q_radius   = q.q_radius;
      req_chan.valid      = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   always @(negedge clock) begin
      rsp_chan.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.note_query(driven_query);
         if (rsp_chan.valid && rsp_chan.ready) sb.check_hit(rsp_chan.hit);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      calm           = 1'b0;
      idle_cycles    = 0;
      driven_query   = '0;
      rsp_chan.ready = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.op    = sbo_pkg::OP_SPHERE;
      {req_chan.obj_x, req_chan.obj_y, req_chan.obj_z, req_chan.obj_radius} = '0;
      {req_chan.q_a_x, req_chan.q_a_y, req_chan.q_a_z} = '0;
      {req_chan.q_b_x, req_chan.q_b_y, req_chan.q_b_z, req_chan.q_radius} = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_query(mk(sbo_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_query(mk(sbo_pkg::OP_SPHERE, F_MIN, F_MIN, F_MIN, F_MAX, F_MAX, F_MAX, F_MAX,
                    0, 0, 0, F_MAX));
      // reach of exactly 2^64 against the widest offset
      send_query(mk(sbo_pkg::OP_SPHERE, F_MIN, 0, 0, F_MIN, F_MAX, 0, 0, 0, 0, 0, F_MIN));
      send_query(mk(sbo_pkg::OP_SPHERE, F_MIN, 1, 0, F_MIN, F_MAX, 0, 0, 0, 0, 0, F_MIN));
      send_query(mk(sbo_pkg::OP_SPHERE, F_MIN, 64'sh2_0000_0000, 0, F_MIN, F_MAX, 0, 0,
                    0, 0, 0, F_MIN));
      // negative reach takes its magnitude
      send_query(mk(sbo_pkg::OP_SPHERE, 3, 0, 0, -5, 0, 0, 0, F_MAX, F_MIN, -1, 2));
      send_query(mk(sbo_pkg::OP_SPHERE, 4, 0, 0, -5, 0, 0, 0, F_MIN, F_MAX, 1, 2));
      send_query(mk(sbo_pkg::OP_SPHERE, 1, 2, 2, 1, 0, 0, 0, 0, 0, 0, 2));
      send_query(mk(sbo_pkg::OP_SPHERE, 1, 2, 2, 1, 0, 0, 0, 0, 0, 0, 1));
      send_query(mk(sbo_pkg::OP_SPHERE, 1, 2, 2, -1, 0, 0, 0, 0, 0, 0, -2));
      send_query(mk(sbo_pkg::OP_SPHERE, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      send_query(mk(sbo_pkg::OP_BOX, 5, 5, 5, 0, 0, 0, 0, 10, 10, 10, F_MIN));
      send_query(mk(sbo_pkg::OP_BOX, 13, 14, 5, 5, 0, 0, 0, 10, 10, 10, F_MAX));
      send_query(mk(sbo_pkg::OP_BOX, 13, 14, 5, -5, 0, 0, 0, 10, 10, 10, 0));
      send_query(mk(sbo_pkg::OP_BOX, 13, 14, 5, 4, 0, 0, 0, 10, 10, 10, 0));
      // inverted box: below min clamps to min, else above max clamps to max
      send_query(mk(sbo_pkg::OP_BOX, 0, 20, -20, 44, 10, 10, 10, -10, -10, -10, 0));
      send_query(mk(sbo_pkg::OP_BOX, 0, 20, -20, 43, 10, 10, 10, -10, -10, -10, 0));
      send_query(mk(sbo_pkg::OP_BOX, F_MIN, F_MIN, F_MIN, F_MIN, F_MAX, F_MAX, F_MAX,
                    F_MAX, F_MAX, F_MAX, F_MIN));
      send_query(mk(sbo_pkg::OP_BOX, F_MIN, 0, 0, F_MIN, F_MIN, 0, 0, F_MAX, 0, 0, F_MAX));
      send_query(mk(sbo_pkg::OP_BOX, F_MAX, 0, 0, F_MIN, F_MIN, 0, 0, F_MIN, 0, 0, F_MIN));
      send_query(mk(sbo_pkg::OP_BOX, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));

      for (int i = 0; i < NUM_ITEMS - 21; i++) begin
         calm = (i >= 300 && i < 450);
         send_query(random_query());
      end
      calm = 1'b0;
      @(negedge clock);
      req_chan.valid = 1'b0;

      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (2 * sbo_pkg::NUM_STAGES + 4) @(posedge clock);
      if (sb.failures == 0 && sb.pending_hits.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
